// File: rtl/ird_pkg.sv
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types, widths and the breakpoint table of the IR distance linearizer.
// ----------------------------------------------------------------------------
package ird_pkg;

	// field and datapath widths
	localparam int CODE_W = 10;              // converter code
	localparam int MM_W   = 9;               // distance in mm
	localparam int RISE_W = 6;               // distance step between knots
	localparam int PROD_W = CODE_W + RISE_W; // offset * rise

	// breakpoint table size
	localparam int KNOTS         = 16;
	localparam int IDX_W         = 4;
	localparam int TABLE_ENTRIES = 16;

	// distance given for a sample above the first knot
	localparam logic [MM_W-1:0] NEAR_MM = 9'd30;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} ird_state_t;

	// divider status seen by the sequencer
	typedef struct packed {
		logic                busy;
		logic                done;
		logic [PROD_W-1:0]   quotient;
	} ird_div_stat_t;

	// knot code: millivolts*1023/3300, truncated
	function automatic logic [CODE_W-1:0] knot_code(input logic [IDX_W-1:0] idx);
		logic [CODE_W-1:0] c;
		case (idx)
			4'd0:    c = 10'd886;  // 2860 mV
			4'd1:    c = 10'd858;  // 2770 mV
			4'd2:    c = 10'd725;  // 2340 mV
			4'd3:    c = 10'd604;  // 1950 mV
			4'd4:    c = 10'd520;  // 1680 mV
			4'd5:    c = 10'd455;  // 1470 mV
			4'd6:    c = 10'd409;  // 1320 mV
			4'd7:    c = 10'd362;  // 1170 mV
			4'd8:    c = 10'd303;  //  980 mV
			4'd9:    c = 10'd251;  //  810 mV
			4'd10:   c = 10'd220;  //  710 mV
			4'd11:   c = 10'd186;  //  600 mV
			4'd12:   c = 10'd161;  //  520 mV
			4'd13:   c = 10'd142;  //  460 mV
			4'd14:   c = 10'd127;  //  410 mV
			4'd15:   c = 10'd96;   //  310 mV
			default: c = 10'd96;
		endcase
		return c;
	endfunction

	// knot distance in mm
	function automatic logic [MM_W-1:0] knot_mm(input logic [IDX_W-1:0] idx);
		logic [MM_W-1:0] m;
		case (idx)
			4'd0:    m = 9'd30;
			4'd1:    m = 9'd40;
			4'd2:    m = 9'd50;
			4'd3:    m = 9'd60;
			4'd4:    m = 9'd70;
			4'd5:    m = 9'd80;
			4'd6:    m = 9'd90;
			4'd7:    m = 9'd100;
			4'd8:    m = 9'd120;
			4'd9:    m = 9'd140;
			4'd10:   m = 9'd160;
			4'd11:   m = 9'd180;
			4'd12:   m = 9'd200;
			4'd13:   m = 9'd220;
			4'd14:   m = 9'd250;
			4'd15:   m = 9'd300;
			default: m = 9'd300;
		endcase
		return m;
	endfunction

endpackage

// File: rtl/ird_div.sv
// ----------------------------------------------------------------------------
// ird_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ird_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ird_pkg::PROD_W-1:0]  dividend,
	input  logic [ird_pkg::CODE_W-1:0]  divisor,
	output ird_pkg::ird_div_stat_t      stat
);

	localparam int CNT_W = $clog2(ird_pkg::PROD_W + 1);
	localparam int REM_W = ird_pkg::CODE_W + 1;

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [ird_pkg::PROD_W-1:0] quo_q;
	logic [REM_W-1:0]           rem_q;
	logic [ird_pkg::CODE_W-1:0] dsr_q;

	logic [REM_W-1:0]           rem_sh;
	logic [REM_W:0]             diff;

	// shift in next dividend bit, trial subtract
	assign rem_sh = {rem_q[REM_W-2:0], quo_q[ird_pkg::PROD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ird_pkg::PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[REM_W]) begin
				rem_q <= diff[REM_W-1:0];
				quo_q <= {quo_q[ird_pkg::PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[ird_pkg::PROD_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign stat.quotient = quo_q;

endmodule

// File: rtl/ir_distance_piecewise_linear.sv
// ----------------------------------------------------------------------------
// ir_distance_piecewise_linear
// Converts a 10-bit IR sensor sample to millimetres by piecewise-linear
// interpolation over a constant breakpoint table.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------
//  sample  | sample_valid / sample_ready | sample[9:0]
//  result  | result_valid / result_ready | distance_mm[8:0], out_of_range
//
// One request: an idle state that accepts it, a scan with one knot compare
// per step up to hit index k, a multiply state, a divide state waiting on the
// divider, and a finish state. Saturated and out-of-range samples skip the divide.
// sample_ready is high only while idle. A finished result waits in the output
// register; the finish cycle stalls only while that register is still full.
// Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module ir_distance_piecewise_linear #(
	parameter int TABLE_ENTRIES = ird_pkg::TABLE_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic [ird_pkg::CODE_W-1:0]  sample,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [ird_pkg::MM_W-1:0]    distance_mm,
	output logic                        out_of_range
);

	// number of knots scanned, clamped to the table
	localparam int SCAN_LEN = (TABLE_ENTRIES > ird_pkg::KNOTS) ? ird_pkg::KNOTS :
	                          (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;
	localparam logic [ird_pkg::IDX_W-1:0] LAST_IDX = ird_pkg::IDX_W'(SCAN_LEN - 1);

	ird_pkg::ird_state_t        state_q, state_d;
	logic [ird_pkg::CODE_W-1:0] sample_q;
	logic [ird_pkg::IDX_W-1:0]  k_q;
	logic [ird_pkg::MM_W-1:0]   dist_q;
	logic                       oor_q;
	logic                       result_valid_q;
	logic [ird_pkg::MM_W-1:0]   distance_mm_q;
	logic                       out_of_range_q;

	logic                       div_start;
	logic                       out_load;
	ird_pkg::ird_div_stat_t     div_stat;

	// table lookups around the current knot
	logic [ird_pkg::IDX_W-1:0]  k_prev;
	logic [ird_pkg::CODE_W-1:0] code_k, code_p;
	logic [ird_pkg::MM_W-1:0]   mm_k, mm_p;
	logic                       above;
	logic [ird_pkg::CODE_W-1:0] off, span;
	logic [ird_pkg::RISE_W-1:0] rise;
	logic [ird_pkg::PROD_W-1:0] prod;

	assign k_prev = k_q - 1'b1;
	assign code_k = ird_pkg::knot_code(k_q);
	assign code_p = ird_pkg::knot_code(k_prev);
	assign mm_k   = ird_pkg::knot_mm(k_q);
	assign mm_p   = ird_pkg::knot_mm(k_prev);
	assign above  = sample_q > code_k;

	// segment offset, rise and span; product feeds the divider register
	assign off  = code_p - sample_q;
	assign span = code_p - code_k;
	assign rise = ird_pkg::RISE_W'(mm_k - mm_p);
	assign prod = {{(ird_pkg::PROD_W - ird_pkg::CODE_W){1'b0}}, off} *
	              {{(ird_pkg::PROD_W - ird_pkg::RISE_W){1'b0}}, rise};

	ird_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (span),
		.stat     (div_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ird_pkg::ST_IDLE: begin
				if (sample_valid) state_d = ird_pkg::ST_SCAN;
			end
			ird_pkg::ST_SCAN: begin
				if (above) begin
					state_d = (k_q == '0) ? ird_pkg::ST_FIN : ird_pkg::ST_MUL;
				end else if (k_q == LAST_IDX) begin
					state_d = ird_pkg::ST_FIN;
				end
			end
			ird_pkg::ST_MUL: state_d = ird_pkg::ST_DIV;
			ird_pkg::ST_DIV: begin
				if (div_stat.done) state_d = ird_pkg::ST_FIN;
			end
			ird_pkg::ST_FIN: begin
				if (out_load) state_d = ird_pkg::ST_IDLE;
			end
			default: state_d = ird_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_ready = 1'b0;
		div_start    = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ird_pkg::ST_IDLE: sample_ready = 1'b1;
			ird_pkg::ST_MUL:  div_start    = 1'b1;
			ird_pkg::ST_FIN:  out_load     = !result_valid_q || result_ready;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ird_pkg::ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ird_pkg::ST_IDLE: begin
				sample_q <= sample;
				k_q      <= '0;
			end
			ird_pkg::ST_SCAN: begin
				if (above) begin
					dist_q <= ird_pkg::NEAR_MM;
					oor_q  <= 1'b0;
				end else if (k_q == LAST_IDX) begin
					dist_q <= '0;
					oor_q  <= 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			ird_pkg::ST_DIV: begin
				if (div_stat.done) begin
					dist_q <= mm_p + div_stat.quotient[ird_pkg::MM_W-1:0];
				end
			end
			default: ;
		endcase
		if (out_load) begin
			distance_mm_q  <= dist_q;
			out_of_range_q <= oor_q;
		end
	end

	assign result_valid = result_valid_q;
	assign distance_mm  = distance_mm_q;
	assign out_of_range = out_of_range_q;

`ifndef SYNTH
	// out-of-range results carry zero distance
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_of_range |-> distance_mm == '0)
		else $error("out_of_range with nonzero distance");

	// in-range results lie within the table span
	a_dist_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_of_range |-> distance_mm >= 9'd30 && distance_mm <= 9'd300)
		else $error("distance outside 30..300 mm");

	// no new request while the divider is running
	a_ready_div: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready |-> !div_stat.busy)
		else $error("ready while divider busy");

	// divider completes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ird_pkg::ST_DIV)
		else $error("divider done outside divide state");
`endif

endmodule
